@@ rtl/assert_macros.svh @@
// assertion macros, included by the fifo top module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define SC2A_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

`define SC2A_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define SC2A_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define SC2A_ASSERT_ALWAYS(label, expr, msg)
`define SC2A_ASSERT_IMPLY(label, ante, cons, msg)
`define SC2A_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

@@ rtl/sc2a_pkg.sv @@
// types, constants and the scancode table of the keyboard receive fifo
package sc2a_pkg;

   localparam int DEPTH = 256;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int FILL_W = 8;
   localparam int WIDE_W = (PTR_W > FILL_W) ? PTR_W : FILL_W;
   localparam int CHAR_W = 7;
   localparam int CODE_W = 8;
   localparam int BREAK_BIT = 7;

   localparam logic [PTR_W-1:0] CNT_MAX = PTR_W'(DEPTH - 1);

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [CHAR_W-1:0] KEY_ESC = 7'h1B;
   localparam logic [CHAR_W-1:0] KEY_BS  = 7'h08;
   localparam logic [CHAR_W-1:0] KEY_TAB = 7'h09;
   localparam logic [CHAR_W-1:0] KEY_LF  = 7'h0A;
   localparam logic [CHAR_W-1:0] NO_CHAR = 7'h00;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   typedef struct packed {
      logic              cmd;
      logic [CODE_W-1:0] scan_byte;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] char_value;
      logic              char_valid;
      logic              stored;
      logic [FILL_W-1:0] fill_level;
   } rsp_type;

   function automatic logic [PTR_W-1:0] ptr_incr(input logic [PTR_W-1:0] ptr);
      return (ptr == CNT_MAX) ? '0 : ptr + 1'b1;
   endfunction

   function automatic logic [FILL_W-1:0] sat_fill(input logic [PTR_W-1:0] cnt);
      logic [WIDE_W-1:0] wide;
      wide = WIDE_W'(cnt);
      return (wide > WIDE_W'(255)) ? {FILL_W{1'b1}} : wide[FILL_W-1:0];
   endfunction

   // set-1 make code to us ascii, zero where unmapped
   function automatic logic [CHAR_W-1:0] us_map(input logic [CHAR_W-1:0] code);
      logic [CHAR_W-1:0] ch;
      case (code)
         7'd1:    ch = KEY_ESC;
         7'd2:    ch = 7'h31;
         7'd3:    ch = 7'h32;
         7'd4:    ch = 7'h33;
         7'd5:    ch = 7'h34;
         7'd6:    ch = 7'h35;
         7'd7:    ch = 7'h36;
         7'd8:    ch = 7'h37;
         7'd9:    ch = 7'h38;
         7'd10:   ch = 7'h39;
         7'd11:   ch = 7'h30;
         7'd12:   ch = 7'h2D;
         7'd13:   ch = 7'h3D;
         7'd14:   ch = KEY_BS;
         7'd15:   ch = KEY_TAB;
         7'd16:   ch = 7'h71;
         7'd17:   ch = 7'h77;
         7'd18:   ch = 7'h65;
         7'd19:   ch = 7'h72;
         7'd20:   ch = 7'h74;
         7'd21:   ch = 7'h79;
         7'd22:   ch = 7'h75;
         7'd23:   ch = 7'h69;
         7'd24:   ch = 7'h6F;
         7'd25:   ch = 7'h70;
         7'd26:   ch = 7'h5B;
         7'd27:   ch = 7'h5D;
         7'd28:   ch = KEY_LF;
         7'd30:   ch = 7'h61;
         7'd31:   ch = 7'h73;
         7'd32:   ch = 7'h64;
         7'd33:   ch = 7'h66;
         7'd34:   ch = 7'h67;
         7'd35:   ch = 7'h68;
         7'd36:   ch = 7'h6A;
         7'd37:   ch = 7'h6B;
         7'd38:   ch = 7'h6C;
         7'd39:   ch = 7'h3B;
         7'd40:   ch = 7'h27;
         7'd41:   ch = 7'h60;
         7'd43:   ch = 7'h5C;
         7'd44:   ch = 7'h7A;
         7'd45:   ch = 7'h78;
         7'd46:   ch = 7'h63;
         7'd47:   ch = 7'h76;
         7'd48:   ch = 7'h62;
         7'd49:   ch = 7'h6E;
         7'd50:   ch = 7'h6D;
         7'd51:   ch = 7'h2C;
         7'd52:   ch = 7'h2E;
         7'd53:   ch = 7'h2F;
         7'd55:   ch = 7'h2A;
         7'd57:   ch = 7'h20;
         7'd74:   ch = 7'h2D;
         7'd78:   ch = 7'h2B;
         default: ch = NO_CHAR;
      endcase
      return ch;
   endfunction

endpackage

@@ rtl/sc2a_ram.sv @@
// generic single-port-write, registered-read ram for the character store
module sc2a_ram #(
   parameter int DEPTH_P = 256,
   parameter int WIDTH_P = 7,
   parameter int ADDR_W_P = $clog2(DEPTH_P)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W_P-1:0] wr_addr,
   input  logic [WIDTH_P-1:0]  wr_data,
   input  logic                rd_en,
   input  logic [ADDR_W_P-1:0] rd_addr,
   output logic [WIDTH_P-1:0]  rd_data
);

   logic [WIDTH_P-1:0] mem [DEPTH_P];
   logic [WIDTH_P-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/scancode_to_ascii_fifo_top.sv @@
// keyboard receive fifo: scancode translation, ring buffer control and response register
//
//   channel   ports                          handshake
//   request   start, busy, req_data          accepted when start && !busy
//   response  rsp_strobe, rsp_data           one-cycle strobe, no back-pressure
//
// a push answers in the cycle after acceptance and the block is ready again at once
// a read passes through the registered ram read port: busy is high while the ram data is
// taken into the response, and the response strobes on the cycle after that
// synchronous reset empties the buffer (pointers and count), ram contents are kept
// the receiver cannot stall, every response is shown for exactly one cycle
module scancode_to_ascii_fifo_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  sc2a_pkg::req_type req_data,
   output logic              rsp_strobe,
   output sc2a_pkg::rsp_type rsp_data
);
   import sc2a_pkg::*;

   `include "assert_macros.svh"

   state_type         state_ff, state_in;
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]  count_ff, count_in;
   rsp_type           rsp_ff, rsp_in;
   logic              strobe_ff, strobe_in;

   logic              accept;
   logic              can_store;
   logic [CHAR_W-1:0] ch;
   logic              mem_we;
   logic              mem_re;
   logic [CHAR_W-1:0] mem_rd_data;

   sc2a_ram #(
      .DEPTH_P (DEPTH),
      .WIDTH_P (CHAR_W),
      .ADDR_W_P(PTR_W)
   ) u_store (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(wr_ptr_ff),
      .wr_data(ch),
      .rd_en  (mem_re),
      .rd_addr(rd_ptr_ff),
      .rd_data(mem_rd_data)
   );

   assign accept = start && (state_ff == ST_IDLE);
   assign ch     = us_map(req_data.scan_byte[CHAR_W-1:0]);

   always_comb begin
      state_in  = state_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      rsp_in    = rsp_ff;
      strobe_in = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      can_store = !req_data.scan_byte[BREAK_BIT] && (ch != NO_CHAR) && (count_ff != CNT_MAX);
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.cmd == CMD_PUSH) begin
                  if (can_store) begin
                     mem_we    = 1'b1;
                     wr_ptr_in = ptr_incr(wr_ptr_ff);
                     count_in  = count_ff + 1'b1;
                  end
                  rsp_in.char_value = NO_CHAR;
                  rsp_in.char_valid = 1'b0;
                  rsp_in.stored     = can_store;
                  rsp_in.fill_level = sat_fill(count_in);
                  strobe_in         = 1'b1;
               end else begin
                  if (count_ff != '0) begin
                     mem_re    = 1'b1;
                     rd_ptr_in = ptr_incr(rd_ptr_ff);
                     count_in  = count_ff - 1'b1;
                  end
                  rsp_in.char_value = NO_CHAR;
                  rsp_in.char_valid = (count_ff != '0);
                  rsp_in.stored     = 1'b0;
                  rsp_in.fill_level = sat_fill(count_in);
                  state_in          = ST_READ;
               end
            end
         end
         ST_READ: begin
            rsp_in.char_value = rsp_ff.char_valid ? mem_rd_data : NO_CHAR;
            strobe_in         = 1'b1;
            state_in          = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   `SC2A_ASSERT_ALWAYS(a_count_max, count_ff <= CNT_MAX, "fill count beyond capacity")
   `SC2A_ASSERT_IMPLY(a_empty_ptrs, count_ff == '0, wr_ptr_ff == rd_ptr_ff, "empty with pointers apart")
   `SC2A_ASSERT_NEXT(a_read_wait, accept && req_data.cmd == CMD_READ, state_ff == ST_READ && !strobe_ff, "read transaction did not wait for ram")
   `SC2A_ASSERT_IMPLY(a_rsp_kind, rsp_strobe, !(rsp_data.stored && rsp_data.char_valid), "response both stored and popped")
   `SC2A_ASSERT_NEXT(a_read_done, state_ff == ST_READ, state_ff == ST_IDLE && strobe_ff, "read response missing")

endmodule

@@ dv/testbench.sv @@
// testbench for the keyboard receive fifo: directed and random scancode pushes and reads
module testbench;
   import sc2a_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   scancode_to_ascii_fifo_top dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // set-1 make code to us ascii
   logic [CHAR_W-1:0] key_chars [0:127] = '{
      'h00, 'h1B, 'h31, 'h32, 'h33, 'h34, 'h35, 'h36,
      'h37, 'h38, 'h39, 'h30, 'h2D, 'h3D, 'h08, 'h09,
      'h71, 'h77, 'h65, 'h72, 'h74, 'h79, 'h75, 'h69,
      'h6F, 'h70, 'h5B, 'h5D, 'h0A, 'h00, 'h61, 'h73,
      'h64, 'h66, 'h67, 'h68, 'h6A, 'h6B, 'h6C, 'h3B,
      'h27, 'h60, 'h00, 'h5C, 'h7A, 'h78, 'h63, 'h76,
      'h62, 'h6E, 'h6D, 'h2C, 'h2E, 'h2F, 'h00, 'h2A,
      'h00, 'h20, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
      'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
      'h00, 'h00, 'h2D, 'h00, 'h00, 'h00, 'h2B, 'h00,
      0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
      0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
      0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0
   };

   logic [CHAR_W-1:0] char_ring [DEPTH];
   int      ring_wr = 0;
   int      ring_rd = 0;
   rsp_type expected_rsp [$];

   int sender_idle_pct = 27;
   int error_count = 0;
   int transaction_count = 0;
   int chars_stored = 0;
   int chars_dropped = 0;
   int chars_read = 0;
   int empty_reads = 0;

   function automatic rsp_type predict_keyboard_step(input req_type item);
      rsp_type           r;
      logic [CHAR_W-1:0] ch;
      int                next_wr;
      int                held;
      r = '0;
      if (item.cmd == CMD_PUSH) begin
         if (!item.scan_byte[BREAK_BIT]) begin
            ch = key_chars[item.scan_byte[CHAR_W-1:0]];
            if (ch != NO_CHAR) begin
               next_wr = (ring_wr + 1) % DEPTH;
               if (next_wr != ring_rd) begin
                  char_ring[ring_wr] = ch;
                  ring_wr = next_wr;
                  r.stored = 1'b1;
                  chars_stored++;
               end else begin
                  chars_dropped++;
               end
            end
         end
      end else if (ring_wr != ring_rd) begin
         r.char_value = char_ring[ring_rd];
         r.char_valid = 1'b1;
         ring_rd = (ring_rd + 1) % DEPTH;
         chars_read++;
      end else begin
         empty_reads++;
      end
      held = (ring_wr + DEPTH - ring_rd) % DEPTH;
      r.fill_level = (held > 255) ? 8'd255 : FILL_W'(held);
      return r;
   endfunction

   task automatic send_item(input req_type item);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy !== 1'b0);
      expected_rsp.push_back(predict_keyboard_step(item));
      transaction_count++;
   endtask

   task automatic push_code(input logic [CODE_W-1:0] code);
      req_type item;
      item.cmd = CMD_PUSH;
      item.scan_byte = code;
      send_item(item);
   endtask

   task automatic read_char(input logic [CODE_W-1:0] junk);
      req_type item;
      item.cmd = CMD_READ;
      item.scan_byte = junk;
      send_item(item);
   endtask

   function automatic logic [CODE_W-1:0] random_make_code();
      logic [CODE_W-1:0] code;
      do code = CODE_W'($urandom_range(127)); while (key_chars[code[CHAR_W-1:0]] == NO_CHAR);
      return code;
   endfunction

   function automatic logic [CODE_W-1:0] random_noise_code();
      logic [CODE_W-1:0] code;
      if ($urandom_range(1)) begin
         code = CODE_W'($urandom_range(255, 128));
      end else begin
         do code = CODE_W'($urandom_range(127)); while (key_chars[code[CHAR_W-1:0]] != NO_CHAR);
      end
      return code;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_rsp.size() == 0) begin
            $error("unexpected transaction: %p", rsp_data);
            error_count++;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.char_value !== want.char_value) begin
               $error("char_value expected %h actual %h", want.char_value, rsp_data.char_value);
               error_count++;
            end
            if (rsp_data.char_valid !== want.char_valid) begin
               $error("char_valid expected %b actual %b", want.char_valid, rsp_data.char_valid);
               error_count++;
            end
            if (rsp_data.stored !== want.stored) begin
               $error("stored expected %b actual %b", want.stored, rsp_data.stored);
               error_count++;
            end
            if (rsp_data.fill_level !== want.fill_level) begin
               $error("fill_level expected %0d actual %0d", want.fill_level, rsp_data.fill_level);
               error_count++;
            end
         end
      end
   end

   task automatic test_empty_reads();
      read_char(8'h00);
      read_char(8'hFF);
   endtask

   task automatic test_special_codes();
      push_code(8'h00);
      push_code(8'h7F);
      push_code(8'h80);
      push_code(8'hFF);
      push_code(8'h9E);
      push_code(8'h1D);
      push_code(8'h01);
      push_code(8'h0E);
      push_code(8'h0F);
      push_code(8'h1C);
      push_code(8'h4A);
      push_code(8'h4E);
      push_code(8'h39);
      push_code(8'h2B);
      repeat (9) read_char(CODE_W'($urandom_range(255)));
   endtask

   // fill until characters are dropped, then read a few back
   task automatic test_full_buffer();
      repeat (DEPTH - 1) push_code(random_make_code());
      push_code(random_make_code());
      push_code(8'h82);
      push_code(random_make_code());
      repeat (16) read_char(CODE_W'($urandom_range(255)));
   endtask

   task automatic test_random_traffic(input int count);
      int push_pct;
      int pick;
      for (int i = 0; i < count; i++) begin
         push_pct = (i < count / 2) ? 65 : 35;
         pick = $urandom_range(99);
         if (pick < 12) begin
            push_code(random_noise_code());
         end else if (pick < 12 + push_pct) begin
            push_code(random_make_code());
         end else begin
            read_char(CODE_W'($urandom_range(255)));
         end
      end
   endtask

   initial begin
      int waited;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_reads();
      test_special_codes();
      test_full_buffer();
      sender_idle_pct = 27;
      test_random_traffic(35);
      sender_idle_pct = 55;
      test_random_traffic(35);
      sender_idle_pct = 0;
      test_random_traffic(35);
      start <= 1'b0;
      waited = 0;
      while (expected_rsp.size() != 0 && waited < 1000) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
      if (expected_rsp.size() != 0) begin
         $error("%0d transactions never answered", expected_rsp.size());
         error_count++;
      end
      $display("%0d transactions: %0d characters buffered, %0d dropped while full",
               transaction_count, chars_stored, chars_dropped);
      $display("%0d characters read back, %0d reads of an empty buffer",
               chars_read, empty_reads);
      if (error_count == 0) begin
         $display("scancode_to_ascii_fifo_top test passed");
      end else begin
         $display("scancode_to_ascii_fifo_top test failed");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("scancode_to_ascii_fifo_top test failed");
      $finish;
   end

endmodule

@@ scancode_to_ascii_fifo_top.f @@
+incdir+rtl
rtl/sc2a_pkg.sv
rtl/sc2a_ram.sv
rtl/scancode_to_ascii_fifo_top.sv
dv/testbench.sv
